[rtl/modular_exponentiation_assert.svh]
// Assertion macros for the modular exponentiation checker.
`ifndef MODULAR_EXPONENTIATION_ASSERT_SVH
`define MODULAR_EXPONENTIATION_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define MEXP_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("modular exponentiation assertion failed");

// Next-cycle implication, disabled during reset.
`define MEXP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("modular exponentiation assertion failed");

`endif

[rtl/mexp_pkg.sv]
// Package with constants for the modular exponentiation block.
package mexp_pkg;

   // Fixed width of the base field
   localparam int BASE_WIDTH = 30;

   // Defaults for the top-level parameters
   localparam int EXP_WIDTH_DEFAULT = 32;
   localparam int MOD_WIDTH_DEFAULT = 30;

   // Modulus after reset
   localparam logic [31:0] MODULUS_RESET = 32'd998244353;

   // Action codes
   localparam logic ACTION_POWER   = 1'b0;
   localparam logic ACTION_INVERSE = 1'b1;

endpackage

[rtl/mexp_if.sv]
// Valid/ready channel interfaces for request and response items.
interface mexp_req_if #(
   parameter int EXP_WIDTH = mexp_pkg::EXP_WIDTH_DEFAULT
);
   logic                            valid;
   logic                            ready;
   logic                            action;
   logic [mexp_pkg::BASE_WIDTH-1:0] base;
   logic [EXP_WIDTH-1:0]            exponent;

   modport source (output valid, action, base, exponent, input ready);
   modport sink (input valid, action, base, exponent, output ready);
endinterface

interface mexp_rsp_if #(
   parameter int MOD_WIDTH = mexp_pkg::MOD_WIDTH_DEFAULT
);
   logic                 valid;
   logic                 ready;
   logic [MOD_WIDTH-1:0] result;

   modport source (output valid, result, input ready);
   modport sink (input valid, result, output ready);
endinterface

[rtl/modular_exponentiation.sv]
// Modular exponentiation by right-to-left square-and-multiply on one shift-add modular multiplier.
//
//   channel   direction  handshake        payload
//   req_chan  in         valid/ready      action, base, exponent
//   rsp_chan  out        valid/ready      result
//   csr       in         csr_we           csr_wdata (modulus)
//
// An item first reduces the base, then runs its squares and multiplies one at a time: the
// shift-add modular multiplier retires one multiplier bit per cycle. Squares and multiplies
// stop at the highest set power bit. req_chan.ready is high only while no item is in work; a
// finished result waits in the output register until taken, and the next item may be
// accepted meanwhile. Reset (synchronous) restores the modulus and clears control state; no
// clearing pass.
module modular_exponentiation #(
   parameter int EXP_WIDTH = mexp_pkg::EXP_WIDTH_DEFAULT,
   parameter int MOD_WIDTH = mexp_pkg::MOD_WIDTH_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   mexp_req_if.sink             req_chan,
   mexp_rsp_if.source           rsp_chan,
   input  logic                 csr_we,
   input  logic [MOD_WIDTH-1:0] csr_wdata
);

   localparam int YW = (mexp_pkg::BASE_WIDTH > MOD_WIDTH) ? mexp_pkg::BASE_WIDTH : MOD_WIDTH;
   localparam int CW = $clog2(YW + 1);
   localparam int TW = MOD_WIDTH + 2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_MUL,
      ST_SQR,
      ST_FINISH
   } state_type;

   state_type            state_ff, state_in;
   logic [MOD_WIDTH-1:0] modulus_ff;
   logic [MOD_WIDTH-1:0] acc_ff, acc_in;
   logic [MOD_WIDTH-1:0] b_ff, b_in;
   logic [MOD_WIDTH-1:0] x_ff, x_in;
   logic [MOD_WIDTH-1:0] p_ff, p_in;
   logic [YW-1:0]        y_ff, y_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic [EXP_WIDTH-1:0] e_ff, e_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [MOD_WIDTH-1:0] res_ff, res_in;

   logic                 req_accept;
   logic [MOD_WIDTH-1:0] addend;
   logic [TW-1:0]        t_sum, t_m1, t_m2, m_ext, m_dbl;
   logic [MOD_WIDTH-1:0] p_next;
   logic [MOD_WIDTH-1:0] mod_minus2;
   logic [EXP_WIDTH-1:0] next_e;

   assign req_chan.ready  = (state_ff == ST_IDLE);
   assign req_accept      = req_chan.valid && req_chan.ready;
   assign rsp_chan.valid  = rsp_valid_ff;
   assign rsp_chan.result = res_ff;

   // Shared unit: p = 2p + ybit * x, reduced by up to two subtractions of m
   assign addend = y_ff[YW-1] ? x_ff : '0;
   assign t_sum  = (TW'(p_ff) << 1) + TW'(addend);
   assign m_ext  = TW'(modulus_ff);
   assign m_dbl  = m_ext << 1;
   assign t_m1   = t_sum - m_ext;
   assign t_m2   = t_sum - m_dbl;
   always_comb begin
      if (t_sum >= m_dbl) begin
         p_next = MOD_WIDTH'(t_m2);
      end else if (t_sum >= m_ext) begin
         p_next = MOD_WIDTH'(t_m1);
      end else begin
         p_next = MOD_WIDTH'(t_sum);
      end
   end

   assign mod_minus2 = modulus_ff - MOD_WIDTH'(2);
   // Power bits still to run after a reduce or square phase
   assign next_e     = (state_ff == ST_SQR) ? (e_ff >> 1) : e_ff;

   // Sequencer next state
   always_comb begin
      state_in     = state_ff;
      acc_in       = acc_ff;
      b_in         = b_ff;
      x_in         = x_ff;
      p_in         = p_ff;
      y_in         = y_ff;
      cnt_in       = cnt_ff;
      e_in         = e_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               acc_in = MOD_WIDTH'(1);
               e_in   = (req_chan.action == mexp_pkg::ACTION_INVERSE) ?
                        EXP_WIDTH'(mod_minus2) : req_chan.exponent;
               // base mod m as base * 1
               x_in   = MOD_WIDTH'(1);
               p_in   = '0;
               y_in   = YW'(req_chan.base) << (YW - mexp_pkg::BASE_WIDTH);
               cnt_in = CW'(mexp_pkg::BASE_WIDTH);
               if (modulus_ff < MOD_WIDTH'(2)) begin
                  acc_in   = '0;
                  state_in = ST_FINISH;
               end else begin
                  state_in = ST_REDUCE;
               end
            end
         end
         ST_REDUCE, ST_SQR: begin
            p_in   = p_next;
            y_in   = y_ff << 1;
            cnt_in = cnt_ff - CW'(1);
            if (cnt_ff == CW'(1)) begin
               b_in = p_next;
               e_in = next_e;
               p_in = '0;
               cnt_in = CW'(MOD_WIDTH);
               x_in = p_next;
               if (next_e == '0) begin
                  state_in = ST_FINISH;
               end else if (next_e[0]) begin
                  y_in     = YW'(acc_ff) << (YW - MOD_WIDTH);
                  state_in = ST_MUL;
               end else begin
                  y_in     = YW'(p_next) << (YW - MOD_WIDTH);
                  state_in = ST_SQR;
               end
            end
         end
         ST_MUL: begin
            p_in   = p_next;
            y_in   = y_ff << 1;
            cnt_in = cnt_ff - CW'(1);
            if (cnt_ff == CW'(1)) begin
               acc_in = p_next;
               p_in   = '0;
               cnt_in = CW'(MOD_WIDTH);
               x_in   = b_ff;
               y_in   = YW'(b_ff) << (YW - MOD_WIDTH);
               // no square needed past the top power bit
               if ((e_ff >> 1) == '0) begin
                  state_in = ST_FINISH;
               end else begin
                  state_in = ST_SQR;
               end
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               res_in       = acc_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State, datapath and output registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         modulus_ff   <= MOD_WIDTH'(mexp_pkg::MODULUS_RESET);
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            modulus_ff <= csr_wdata;
         end
      end
      acc_ff <= acc_in;
      b_ff   <= b_in;
      x_ff   <= x_in;
      p_ff   <= p_in;
      y_ff   <= y_in;
      cnt_ff <= cnt_in;
      e_ff   <= e_in;
      res_ff <= res_in;
   end

endmodule

[rtl/mexp_checker.sv]
// Port-level checker for the modular exponentiation block, with its bind.
`include "modular_exponentiation_assert.svh"

module mexp_checker #(
   parameter int MOD_WIDTH = mexp_pkg::MOD_WIDTH_DEFAULT
) (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic [MOD_WIDTH-1:0] result,
   input logic                 csr_we,
   input logic [MOD_WIDTH-1:0] csr_wdata
);

   logic [MOD_WIDTH-1:0] mod_ff;
   logic                 rsp_in_range;

   // Shadow copy of the modulus from the write port
   always_ff @(posedge clock) begin
      if (reset) begin
         mod_ff <= MOD_WIDTH'(mexp_pkg::MODULUS_RESET);
      end else if (csr_we) begin
         mod_ff <= csr_wdata;
      end
   end

   assign rsp_in_range = (mod_ff < MOD_WIDTH'(2)) ? (result == '0) : (result < mod_ff);

   // A stalled result keeps its value
   `MEXP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, $stable(result))
   // Every result lies below the modulus, or is zero for a degenerate modulus
   `MEXP_ASSERT_IMPLY(a_rsp_range, clock, reset, rsp_valid, rsp_in_range)
   // An accepted item keeps the block busy for the next cycle
   `MEXP_ASSERT_NEXT(a_busy, clock, reset, req_valid && req_ready, !req_ready)

endmodule

bind modular_exponentiation mexp_checker #(
   .MOD_WIDTH (MOD_WIDTH)
) u_mexp_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .result    (rsp_chan.result),
   .csr_we    (csr_we),
   .csr_wdata (csr_wdata)
);
